// ===== src/kabf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_pkg
// Shared types and fixed-point constants of the angle/bias Kalman filter.
// ----------------------------------------------------------------------------
`default_nettype none

package kabf_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int COV_WIDTH     = 48;
    localparam int TIME_FRAC     = 16;
    localparam int GAIN_FRAC     = 24;

    localparam int ANGLE_W = 25;
    localparam int RATE_W  = 28;
    localparam int DT_W    = 16;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int Y_W     = ANGLE_W + 1;
    localparam int S_W     = COV_WIDTH + 2;

    localparam logic signed [63:0] ANGLE_LIMIT = 64'sd180 <<< FRACTION_BITS;
    localparam logic signed [63:0] BIAS_LIMIT  = 64'sd2000 <<< FRACTION_BITS;
    localparam logic signed [63:0] COV_LIMIT   = (64'sd1 <<< (COV_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] WIDE_LIMIT  = 64'sh7FFF_FFFF_FFFF_FFFF;

    localparam logic [CFG_W-1:0] ANGLE_Q_RESET = 32'd16777;
    localparam logic [CFG_W-1:0] BIAS_Q_RESET  = 32'd50332;
    localparam logic [CFG_W-1:0] MEAS_R_RESET  = 32'd503316;

    localparam logic [IDX_W-1:0] CFG_ANGLE_Q = 2'd0;
    localparam logic [IDX_W-1:0] CFG_BIAS_Q  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MEAS_R  = 2'd2;

    typedef enum logic [4:0] {
        STEP_RATE, STEP_T, STEP_ACC1, STEP_ACC2, STEP_U, STEP_PT1, STEP_PT2,
        STEP_V, STEP_S, STEP_K0, STEP_K1, STEP_A, STEP_B,
        STEP_C00, STEP_C01, STEP_C10, STEP_C11
    } t_step;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

endpackage

`default_nettype wire

// ===== src/kabf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_mul
// Iterative signed multiply with round-to-nearest shift and saturation,
// built from four 32x32 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module kabf_mul (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_a,
    input  wire logic signed [63:0] i_b,
    input  wire logic               i_frac24,
    input  wire logic               i_cov,
    output logic                    o_done,
    output logic signed [63:0]      o_result
);

    logic [63:0]        r_ma, r_mb, r_pp;
    logic [127:0]       r_acc;
    logic               r_neg, r_f24, r_cov, r_busy, r_done;
    logic [2:0]         r_cnt;
    logic signed [63:0] r_res;

    logic [31:0]  op_x, op_y;
    logic [63:0]  pp_n, lim, mag;
    logic [127:0] shifted, half;

    always_comb begin
        op_x    = r_cnt[1] ? r_ma[63:32] : r_ma[31:0];
        op_y    = r_cnt[0] ? r_mb[63:32] : r_mb[31:0];
        pp_n    = op_x * op_y;
        half    = r_f24 ? (128'd1 << (kabf_pkg::GAIN_FRAC - 1))
                        : (128'd1 << (kabf_pkg::TIME_FRAC - 1));
        shifted = r_f24 ? (r_acc >> kabf_pkg::GAIN_FRAC) : (r_acc >> kabf_pkg::TIME_FRAC);
        lim     = r_cov ? 64'(kabf_pkg::COV_LIMIT) : 64'(kabf_pkg::WIDE_LIMIT);
        mag     = (shifted > {64'd0, lim}) ? lim : shifted[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd6) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ma  <= i_a[63] ? 64'(-i_a) : 64'(i_a);
            r_mb  <= i_b[63] ? 64'(-i_b) : 64'(i_b);
            r_neg <= i_a[63] ^ i_b[63];
            r_f24 <= i_frac24;
            r_cov <= i_cov;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt <= 3'd3) begin
                r_pp <= pp_n;
            end
            unique case (r_cnt)
                3'd1:    r_acc <= r_acc + {64'd0, r_pp};
                3'd2,
                3'd3:    r_acc <= r_acc + {32'd0, r_pp, 32'd0};
                3'd4:    r_acc <= r_acc + {r_pp, 64'd0};
                3'd5:    r_acc <= r_acc + half;
                3'd6:    r_res <= r_neg ? -$signed(mag) : $signed(mag);
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== src/kabf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kabf_div
// Bit-serial restoring divide: trunc(num * 2^24 / den), saturated and signed.
// ----------------------------------------------------------------------------
`default_nettype none

module kabf_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic signed [63:0] i_den,
    output logic                    o_done,
    output logic signed [63:0]      o_result
);

    logic [63:0]        r_r, r_lo, r_q, r_d;
    logic               r_neg, r_ovf, r_busy, r_last, r_done;
    logic [5:0]         r_cnt;
    logic signed [63:0] r_res;

    logic [63:0] n_mag, d_mag, r2, qc;
    logic        sub;

    always_comb begin
        n_mag = i_num[63] ? 64'(-i_num) : 64'(i_num);
        d_mag = i_den[63] ? 64'(-i_den) : 64'(i_den);
        r2    = {r_r[62:0], r_lo[63]};
        sub   = r_r[63] || (r2 >= r_d);
        qc    = r_q[63] ? 64'(kabf_pkg::WIDE_LIMIT) : r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_last <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            r_last <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_ovf || r_cnt == 6'd63)) begin
                r_busy <= 1'b0;
                r_last <= !r_ovf;
                r_done <= r_ovf;
            end else if (r_last) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r   <= n_mag >> (64 - kabf_pkg::GAIN_FRAC);
            r_lo  <= n_mag << kabf_pkg::GAIN_FRAC;
            r_d   <= d_mag;
            r_q   <= '0;
            r_neg <= i_num[63] ^ i_den[63];
            r_ovf <= (n_mag >> (64 - kabf_pkg::GAIN_FRAC)) >= d_mag;
            r_cnt <= '0;
        end else if (r_busy) begin
            if (r_ovf) begin
                r_res <= r_neg ? -kabf_pkg::WIDE_LIMIT : kabf_pkg::WIDE_LIMIT;
            end else begin
                r_r   <= sub ? (r2 - r_d) : r2;
                r_lo  <= {r_lo[62:0], 1'b0};
                r_q   <= {r_q[62:0], sub};
                r_cnt <= r_cnt + 6'd1;
            end
        end else if (r_last) begin
            r_res <= r_neg ? -$signed(qc) : $signed(qc);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== src/kalman_angle_bias_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// Two-state angle / gyro-bias Kalman filter sequenced over a shared
// multiplier and a bit-serial divider.
// Sequence: each request runs 10 multiplies, 2 divides, 5 adds and 1 output
//   load; a zero innovation variance skips the divides (zero gain); forced skips all.
// Flow: one request at a time; a new request is taken only after the last
//   result has been loaded into the output registers.
// Reset: synchronous active low; state and covariance clear to zero, noise
//   registers load their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module kalman_angle_bias_filter (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic signed [24:0]  i_measured_angle,
    input  wire logic signed [27:0]  i_measured_rate,
    input  wire logic [15:0]         i_time_step,
    input  wire logic                i_force_angle,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic signed [24:0]       o_angle_estimate,
    output logic signed [27:0]       o_bias_estimate,
    input  wire logic                i_cfg_we,
    input  wire logic [1:0]          i_cfg_index,
    input  wire logic [31:0]         i_cfg_data
);

    localparam int CW = kabf_pkg::COV_WIDTH;

    kabf_pkg::t_state r_state;
    kabf_pkg::t_step  r_step;

    logic [31:0] r_qa, r_qb, r_rm;
    logic signed [24:0] r_angle, r_meas, r_o_angle;
    logic signed [27:0] r_bias, r_rate, r_o_bias;
    logic [15:0] r_dt;
    logic signed [CW-1:0] r_p00, r_p01, r_p10, r_p11, r_acc, r_t, r_c00, r_c01;
    logic signed [kabf_pkg::S_W-1:0] r_s;
    logic signed [kabf_pkg::Y_W-1:0] r_y;
    logic signed [63:0] r_k0, r_k1;
    logic r_out_valid;

    logic signed [63:0] m_a, m_b, add_a, add_b, add_lim, sat, mul_res, div_res;
    logic signed [64:0] sum;
    logic signed [24:0] force_val;
    logic m_f24, m_cov, mul_start, div_start, mul_done, div_done, is_mul, accept, load;

    assign accept = i_in_valid && o_in_ready;
    assign load   = (r_state == kabf_pkg::ST_FIN) && (!r_out_valid || i_out_ready);

    always_comb begin
        m_a = '0; m_b = '0; m_f24 = 1'b0; m_cov = 1'b0; is_mul = 1'b1;
        add_a = '0; add_b = '0; add_lim = kabf_pkg::COV_LIMIT;
        unique case (r_step)
            kabf_pkg::STEP_RATE: begin
                m_a = 64'(r_dt); m_b = 64'(r_rate) - 64'(r_bias);
                add_a = 64'(r_angle); add_b = mul_res; add_lim = kabf_pkg::ANGLE_LIMIT;
            end
            kabf_pkg::STEP_T: begin
                m_a = 64'(r_dt); m_b = 64'(r_p11); m_cov = 1'b1;
                add_a = mul_res; add_b = -64'(r_p01);
            end
            kabf_pkg::STEP_ACC1: begin
                is_mul = 1'b0; add_a = 64'(r_acc); add_b = -64'(r_p10);
            end
            kabf_pkg::STEP_ACC2: begin
                is_mul = 1'b0; add_a = 64'(r_acc); add_b = $signed(64'(r_qa));
            end
            kabf_pkg::STEP_U: begin
                m_a = 64'(r_dt); m_b = 64'(r_acc); m_cov = 1'b1;
                add_a = 64'(r_p00); add_b = mul_res;
            end
            kabf_pkg::STEP_PT1: begin
                is_mul = 1'b0; add_a = 64'(r_p01); add_b = -64'(r_t);
            end
            kabf_pkg::STEP_PT2: begin
                is_mul = 1'b0; add_a = 64'(r_p10); add_b = -64'(r_t);
            end
            kabf_pkg::STEP_V: begin
                m_a = $signed(64'(r_qb)); m_b = 64'(r_dt); m_cov = 1'b1;
                add_a = 64'(r_p11); add_b = mul_res;
            end
            kabf_pkg::STEP_S: begin
                is_mul = 1'b0; add_a = 64'(r_p00); add_b = $signed(64'(r_rm));
                add_lim = kabf_pkg::WIDE_LIMIT;
            end
            kabf_pkg::STEP_K0, kabf_pkg::STEP_K1: begin
                is_mul = 1'b0;
            end
            kabf_pkg::STEP_A: begin
                m_a = r_k0; m_b = 64'(r_y); m_f24 = 1'b1;
                add_a = 64'(r_angle); add_b = mul_res; add_lim = kabf_pkg::ANGLE_LIMIT;
            end
            kabf_pkg::STEP_B: begin
                m_a = r_k1; m_b = 64'(r_y); m_f24 = 1'b1;
                add_a = 64'(r_bias); add_b = mul_res; add_lim = kabf_pkg::BIAS_LIMIT;
            end
            kabf_pkg::STEP_C00: begin
                m_a = r_k0; m_b = 64'(r_c00); m_f24 = 1'b1; m_cov = 1'b1;
                add_a = 64'(r_p00); add_b = -mul_res;
            end
            kabf_pkg::STEP_C01: begin
                m_a = r_k0; m_b = 64'(r_c01); m_f24 = 1'b1; m_cov = 1'b1;
                add_a = 64'(r_p01); add_b = -mul_res;
            end
            kabf_pkg::STEP_C10: begin
                m_a = r_k1; m_b = 64'(r_c00); m_f24 = 1'b1; m_cov = 1'b1;
                add_a = 64'(r_p10); add_b = -mul_res;
            end
            kabf_pkg::STEP_C11: begin
                m_a = r_k1; m_b = 64'(r_c01); m_f24 = 1'b1; m_cov = 1'b1;
                add_a = 64'(r_p11); add_b = -mul_res;
            end
            default: is_mul = 1'b0;
        endcase

        sum = 65'(add_a) + 65'(add_b);
        priority if (sum > 65'(add_lim)) begin
            sat = add_lim;
        end else if (sum < -65'(add_lim)) begin
            sat = -add_lim;
        end else begin
            sat = sum[63:0];
        end

        priority if (i_measured_angle > 25'(kabf_pkg::ANGLE_LIMIT)) begin
            force_val = 25'(kabf_pkg::ANGLE_LIMIT);
        end else if (i_measured_angle < -25'(kabf_pkg::ANGLE_LIMIT)) begin
            force_val = -25'(kabf_pkg::ANGLE_LIMIT);
        end else begin
            force_val = i_measured_angle;
        end
    end

    assign mul_start = (r_state == kabf_pkg::ST_RUN) && is_mul;
    assign div_start = (r_state == kabf_pkg::ST_RUN) &&
                       ((r_step == kabf_pkg::STEP_K0 && r_s != '0) ||
                        r_step == kabf_pkg::STEP_K1);

    kabf_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mul_start),
        .i_a      (m_a),
        .i_b      (m_b),
        .i_frac24 (m_f24),
        .i_cov    (m_cov),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    kabf_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    ((r_step == kabf_pkg::STEP_K0) ? 64'(r_p00) : 64'(r_p10)),
        .i_den    (64'(r_s)),
        .o_done   (div_done),
        .o_result (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qa <= kabf_pkg::ANGLE_Q_RESET;
            r_qb <= kabf_pkg::BIAS_Q_RESET;
            r_rm <= kabf_pkg::MEAS_R_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                kabf_pkg::CFG_ANGLE_Q: r_qa <= i_cfg_data;
                kabf_pkg::CFG_BIAS_Q:  r_qb <= i_cfg_data;
                kabf_pkg::CFG_MEAS_R:  r_rm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_meas <= i_measured_angle;
            r_rate <= i_measured_rate;
            r_dt   <= i_time_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kabf_pkg::ST_IDLE;
            r_step  <= kabf_pkg::STEP_RATE;
            r_angle <= '0;
            r_bias  <= '0;
            r_p00   <= '0;
            r_p01   <= '0;
            r_p10   <= '0;
            r_p11   <= '0;
        end else begin
            unique case (r_state)
                kabf_pkg::ST_IDLE: begin
                    if (accept) begin
                        r_step <= kabf_pkg::STEP_RATE;
                        if (i_force_angle) begin
                            r_angle <= force_val;
                            r_state <= kabf_pkg::ST_FIN;
                        end else begin
                            r_state <= kabf_pkg::ST_RUN;
                        end
                    end
                end
                kabf_pkg::ST_RUN: begin
                    if (is_mul) begin
                        r_state <= kabf_pkg::ST_WAIT;
                    end else begin
                        unique case (r_step)
                            kabf_pkg::STEP_ACC1: begin
                                r_acc <= CW'(sat); r_step <= kabf_pkg::STEP_ACC2;
                            end
                            kabf_pkg::STEP_ACC2: begin
                                r_acc <= CW'(sat); r_step <= kabf_pkg::STEP_U;
                            end
                            kabf_pkg::STEP_PT1: begin
                                r_p01 <= CW'(sat); r_step <= kabf_pkg::STEP_PT2;
                            end
                            kabf_pkg::STEP_PT2: begin
                                r_p10 <= CW'(sat); r_step <= kabf_pkg::STEP_V;
                            end
                            kabf_pkg::STEP_S: begin
                                r_s   <= kabf_pkg::S_W'(sat);
                                r_c00 <= r_p00;
                                r_c01 <= r_p01;
                                r_y   <= kabf_pkg::Y_W'(r_meas) - kabf_pkg::Y_W'(r_angle);
                                r_step <= kabf_pkg::STEP_K0;
                            end
                            kabf_pkg::STEP_K0: begin
                                if (r_s == '0) begin
                                    r_k0   <= '0;
                                    r_k1   <= '0;
                                    r_step <= kabf_pkg::STEP_A;
                                end else begin
                                    r_state <= kabf_pkg::ST_WAIT;
                                end
                            end
                            default: r_state <= kabf_pkg::ST_WAIT;
                        endcase
                    end
                end
                kabf_pkg::ST_WAIT: begin
                    if (mul_done || div_done) begin
                        r_state <= kabf_pkg::ST_RUN;
                        unique case (r_step)
                            kabf_pkg::STEP_RATE: begin
                                r_angle <= 25'(sat); r_step <= kabf_pkg::STEP_T;
                            end
                            kabf_pkg::STEP_T: begin
                                r_t <= CW'(mul_res); r_acc <= CW'(sat);
                                r_step <= kabf_pkg::STEP_ACC1;
                            end
                            kabf_pkg::STEP_U: begin
                                r_p00 <= CW'(sat); r_step <= kabf_pkg::STEP_PT1;
                            end
                            kabf_pkg::STEP_V: begin
                                r_p11 <= CW'(sat); r_step <= kabf_pkg::STEP_S;
                            end
                            kabf_pkg::STEP_K0: begin
                                r_k0 <= div_res; r_step <= kabf_pkg::STEP_K1;
                            end
                            kabf_pkg::STEP_K1: begin
                                r_k1 <= div_res; r_step <= kabf_pkg::STEP_A;
                            end
                            kabf_pkg::STEP_A: begin
                                r_angle <= 25'(sat); r_step <= kabf_pkg::STEP_B;
                            end
                            kabf_pkg::STEP_B: begin
                                r_bias <= 28'(sat); r_step <= kabf_pkg::STEP_C00;
                            end
                            kabf_pkg::STEP_C00: begin
                                r_p00 <= CW'(sat); r_step <= kabf_pkg::STEP_C01;
                            end
                            kabf_pkg::STEP_C01: begin
                                r_p01 <= CW'(sat); r_step <= kabf_pkg::STEP_C10;
                            end
                            kabf_pkg::STEP_C10: begin
                                r_p10 <= CW'(sat); r_step <= kabf_pkg::STEP_C11;
                            end
                            kabf_pkg::STEP_C11: begin
                                r_p11 <= CW'(sat); r_state <= kabf_pkg::ST_FIN;
                            end
                            default: r_state <= kabf_pkg::ST_WAIT;
                        endcase
                    end
                end
                kabf_pkg::ST_FIN: begin
                    if (load) begin
                        r_state <= kabf_pkg::ST_IDLE;
                    end
                end
                default: r_state <= kabf_pkg::ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_angle <= r_angle;
            r_o_bias  <= r_bias;
        end
    end

    assign o_in_ready       = (r_state == kabf_pkg::ST_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_angle_estimate = r_o_angle;
    assign o_bias_estimate  = r_o_bias;

endmodule

`default_nettype wire
